/* design/ppst_pkg.sv */
// ppst_pkg: shared types and constants of the pure pursuit steering block.
// Holds register codes, reset values, datapath widths, the controller state
// type and the command/status structs between controller and datapath.
package ppst_pkg;

  localparam int PATH_DEPTH_DEF = 256;

  localparam int CFG_W  = 31;   // width of every configuration register
  localparam int IDXR_W = 2;    // configuration register index width

  localparam logic [IDXR_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [IDXR_W-1:0] REG_MAX_SPEED = 2'd1;
  localparam logic [IDXR_W-1:0] REG_MAX_TURN  = 2'd2;
  localparam logic [IDXR_W-1:0] REG_STOP      = 2'd3;

  localparam logic [CFG_W-1:0] LOOKAHEAD_RST = 31'd65536;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd32768;
  localparam logic [CFG_W-1:0] MAX_TURN_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] STOP_RST      = 31'd6554;

  localparam int DIFF_W = 33;   // coordinate difference, signed
  localparam int D2_W   = 66;   // squared distance
  localparam int ROOT_W = 33;   // floor square root of a squared distance
  localparam int REM_W  = 35;   // square root remainder
  localparam int LAT_W  = 50;   // lateral offset, signed
  localparam int HALF_W = 25;   // half of the lateral magnitude for the split product
  localparam int PP_W   = 58;   // partial product of the numerator
  localparam int NUM_W  = 84;   // division numerator
  localparam int DSH_W  = 97;   // shifted divisor
  localparam int QUO_W  = 32;   // quotient
  localparam int ITER_W = 6;

  localparam logic [ITER_W-1:0] SQRT_LAST_ITER = 6'd32;
  localparam logic [ITER_W-1:0] DIV_LAST_ITER  = 6'd31;

  // sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_C1 = 15'd21024;
  localparam logic [11:0] SIN_C2 = 12'd2320;
  localparam logic [15:0] SIN_C3 = 16'd51472;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_NEXT,
    ADDR_LAST,
    ADDR_LA
  } addr_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_RD, ST_S_MUL, ST_S_ADD, ST_S_CMP,
    ST_W_INIT, ST_W_RDP, ST_W_PREV, ST_W_CHK, ST_W_RDN, ST_W_MUL, ST_W_ADD,
    ST_W_SQ0, ST_W_SQ, ST_W_ACC, ST_W_TST,
    ST_F_RD, ST_F_MUL, ST_F_ADD, ST_F_REACH,
    ST_T_RD, ST_T_MUL, ST_T_ADD, ST_T_CHK,
    ST_N_LO, ST_N_HI, ST_N_ADD, ST_D0, ST_D,
    ST_FINISH
  } ppst_state_t;

  typedef struct packed {
    logic      pose_cap;
    logic      pt_write;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      sq_prev;
    logic      sq_mul;
    logic      sq_add;
    logic      best_upd;
    logic      idx_clr;
    logic      idx_inc;
    logic      walk_init;
    logic      prev_load;
    logic      sqrt_start;
    logic      sqrt_step;
    logic      acc_add;
    logic      reach_load;
    logic      lat_mul;
    logic      lat_add;
    logic      num_lo;
    logic      num_hi;
    logic      num_add;
    logic      div_start;
    logic      div_step;
    logic      out_load;
  } ppst_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_idx;
    logic has_next;
    logic iter_last;
    logic acc_ge;
    logic d2_zero;
  } ppst_sts_t;

endpackage

/* design/ppst_ctrl.sv */
// ppst_ctrl: sequencer of the pure pursuit steering block.
// Drives ppst_dp through ppst_pkg command/status structs; owns the
// input stall and the output valid flag.
module ppst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ppst_pkg::ppst_sts_t  sts,
  output ppst_pkg::ppst_cmd_t  cmd
);

  ppst_pkg::ppst_state_t state, state_next;
  logic in_xfer;

  assign in_stall = (state != ppst_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result valid: set on load, cleared by an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = ppst_pkg::ADDR_IDX;
    unique case (state)
      ppst_pkg::ST_IDLE: begin
        if (in_xfer && !mode) begin
          cmd.pt_write = 1'b1;
        end else if (in_xfer) begin
          cmd.pose_cap = 1'b1;
          if (sts.count_zero) begin
            state_next = ppst_pkg::ST_FINISH;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = ppst_pkg::ST_S_RD;
          end
        end
      end
      // closest point search
      ppst_pkg::ST_S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ppst_pkg::ST_S_MUL;
      end
      ppst_pkg::ST_S_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = ppst_pkg::ST_S_ADD;
      end
      ppst_pkg::ST_S_ADD: begin
        cmd.sq_add = 1'b1;
        state_next = ppst_pkg::ST_S_CMP;
      end
      ppst_pkg::ST_S_CMP: begin
        cmd.best_upd = 1'b1;
        if (sts.last_idx) begin
          state_next = ppst_pkg::ST_W_INIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ppst_pkg::ST_S_RD;
        end
      end
      // lookahead walk
      ppst_pkg::ST_W_INIT: begin
        cmd.walk_init = 1'b1;
        state_next    = ppst_pkg::ST_W_RDP;
      end
      ppst_pkg::ST_W_RDP: begin
        cmd.rd_en  = 1'b1;
        state_next = ppst_pkg::ST_W_PREV;
      end
      ppst_pkg::ST_W_PREV: begin
        cmd.prev_load = 1'b1;
        state_next    = ppst_pkg::ST_W_CHK;
      end
      ppst_pkg::ST_W_CHK: begin
        state_next = sts.has_next ? ppst_pkg::ST_W_RDN : ppst_pkg::ST_F_RD;
      end
      ppst_pkg::ST_W_RDN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ppst_pkg::ADDR_NEXT;
        state_next = ppst_pkg::ST_W_MUL;
      end
      ppst_pkg::ST_W_MUL: begin
        cmd.sq_mul  = 1'b1;
        cmd.sq_prev = 1'b1;
        state_next  = ppst_pkg::ST_W_ADD;
      end
      ppst_pkg::ST_W_ADD: begin
        cmd.sq_add = 1'b1;
        state_next = ppst_pkg::ST_W_SQ0;
      end
      ppst_pkg::ST_W_SQ0: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ppst_pkg::ST_W_SQ;
      end
      ppst_pkg::ST_W_SQ: begin
        cmd.sqrt_step = 1'b1;
        if (sts.iter_last) begin
          state_next = ppst_pkg::ST_W_ACC;
        end
      end
      ppst_pkg::ST_W_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ppst_pkg::ST_W_TST;
      end
      ppst_pkg::ST_W_TST: begin
        state_next = sts.acc_ge ? ppst_pkg::ST_F_RD : ppst_pkg::ST_W_CHK;
      end
      // final point, reached test
      ppst_pkg::ST_F_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ppst_pkg::ADDR_LAST;
        state_next = ppst_pkg::ST_F_MUL;
      end
      ppst_pkg::ST_F_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = ppst_pkg::ST_F_ADD;
      end
      ppst_pkg::ST_F_ADD: begin
        cmd.sq_add = 1'b1;
        state_next = ppst_pkg::ST_F_REACH;
      end
      ppst_pkg::ST_F_REACH: begin
        cmd.reach_load = 1'b1;
        state_next     = ppst_pkg::ST_T_RD;
      end
      // target point: distance and lateral offset
      ppst_pkg::ST_T_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ppst_pkg::ADDR_LA;
        state_next = ppst_pkg::ST_T_MUL;
      end
      ppst_pkg::ST_T_MUL: begin
        cmd.sq_mul  = 1'b1;
        cmd.lat_mul = 1'b1;
        state_next  = ppst_pkg::ST_T_ADD;
      end
      ppst_pkg::ST_T_ADD: begin
        cmd.sq_add  = 1'b1;
        cmd.lat_add = 1'b1;
        state_next  = ppst_pkg::ST_T_CHK;
      end
      ppst_pkg::ST_T_CHK: begin
        state_next = sts.d2_zero ? ppst_pkg::ST_FINISH : ppst_pkg::ST_N_LO;
      end
      // turn rate numerator and division
      ppst_pkg::ST_N_LO: begin
        cmd.num_lo = 1'b1;
        state_next = ppst_pkg::ST_N_HI;
      end
      ppst_pkg::ST_N_HI: begin
        cmd.num_hi = 1'b1;
        state_next = ppst_pkg::ST_N_ADD;
      end
      ppst_pkg::ST_N_ADD: begin
        cmd.num_add = 1'b1;
        state_next  = ppst_pkg::ST_D0;
      end
      ppst_pkg::ST_D0: begin
        cmd.div_start = 1'b1;
        state_next    = ppst_pkg::ST_D;
      end
      ppst_pkg::ST_D: begin
        cmd.div_step = 1'b1;
        if (sts.iter_last) begin
          state_next = ppst_pkg::ST_FINISH;
        end
      end
      ppst_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ppst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/ppst_dp.sv */
// ppst_dp: datapath of the pure pursuit steering block.
// Path store, configuration registers, distance, square root, sine and
// division units and the result register; sequenced by ppst_ctrl.
module ppst_dp #(
  parameter int PATH_DEPTH = ppst_pkg::PATH_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppst_pkg::ppst_cmd_t               cmd,
  output ppst_pkg::ppst_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [ppst_pkg::IDXR_W-1:0]       cfg_index,
  input  logic [ppst_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              restart_path,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  input  logic [15:0]                       heading,
  output logic signed [31:0]                speed_cmd,
  output logic signed [31:0]                turn_cmd,
  output logic [7:0]                        target_index,
  output logic                              reached
);

  localparam int IDX_W = $clog2(PATH_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int ACC_W = ppst_pkg::ROOT_W + CNT_W;

  // configuration registers
  logic [ppst_pkg::CFG_W-1:0] la_dist, max_speed, max_turn, stop_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      la_dist   <= ppst_pkg::LOOKAHEAD_RST;
      max_speed <= ppst_pkg::MAX_SPEED_RST;
      max_turn  <= ppst_pkg::MAX_TURN_RST;
      stop_m    <= ppst_pkg::STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppst_pkg::REG_LOOKAHEAD: la_dist   <= cfg_data;
        ppst_pkg::REG_MAX_SPEED: max_speed <= cfg_data;
        ppst_pkg::REG_MAX_TURN:  max_turn  <= cfg_data;
        ppst_pkg::REG_STOP:      stop_m    <= cfg_data;
        default: ;
      endcase
    end
  end

  // path store and fill count
  logic [31:0]      mem_x [PATH_DEPTH];
  logic [31:0]      mem_y [PATH_DEPTH];
  logic [CNT_W-1:0] count, cnt_m1;
  logic [IDX_W-1:0] waddr, raddr, idx, la, best;
  logic             wr_ok;
  logic [31:0]      pt_x, pt_y;

  assign cnt_m1 = count - 1'b1;
  assign wr_ok  = restart_path || (count < CNT_W'(PATH_DEPTH));
  assign waddr  = restart_path ? '0 : count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pt_write) begin
      if (restart_path) begin
        count <= CNT_W'(1);
      end else if (wr_ok) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_write && wr_ok) begin
      mem_x[waddr] <= pos_x;
      mem_y[waddr] <= pos_y;
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      ppst_pkg::ADDR_IDX:  raddr = idx;
      ppst_pkg::ADDR_NEXT: raddr = idx + 1'b1;
      ppst_pkg::ADDR_LAST: raddr = cnt_m1[IDX_W-1:0];
      ppst_pkg::ADDR_LA:   raddr = la;
      default:             raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pt_x <= mem_x[raddr];
      pt_y <= mem_y[raddr];
    end
  end

  // pose capture
  logic [31:0] px, py, prev_x, prev_y;
  logic [15:0] hd;
  logic        empty;

  always_ff @(posedge clk) begin
    if (cmd.pose_cap) begin
      px    <= pos_x;
      py    <= pos_y;
      hd    <= heading;
      empty <= (count == '0);
    end
  end

  // difference of the read point to the pose or to the previous point
  logic [31:0]                       ox, oy;
  logic signed [ppst_pkg::DIFF_W-1:0] dxs, dys;
  logic [ppst_pkg::DIFF_W-1:0]        ax, ay;
  logic [ppst_pkg::D2_W-1:0]          sqx, sqy, d2, best_d;

  assign ox  = cmd.sq_prev ? prev_x : px;
  assign oy  = cmd.sq_prev ? prev_y : py;
  assign dxs = $signed({pt_x[31], pt_x}) - $signed({ox[31], ox});
  assign dys = $signed({pt_y[31], pt_y}) - $signed({oy[31], oy});
  assign ax  = dxs[ppst_pkg::DIFF_W-1] ? ppst_pkg::DIFF_W'(-dxs) : dxs;
  assign ay  = dys[ppst_pkg::DIFF_W-1] ? ppst_pkg::DIFF_W'(-dys) : dys;

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
    if (cmd.sq_add) begin
      d2 <= sqx + sqy;
    end
  end

  // closest search, walk indices, arc length accumulator
  logic [ACC_W-1:0]            acc;
  logic [ppst_pkg::ROOT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (cmd.best_upd && (idx == '0 || d2 < best_d)) begin
      best_d <= d2;
      best   <= idx;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.walk_init) begin
      idx <= best;
    end else if (cmd.acc_add) begin
      idx <= idx + 1'b1;
    end
    if (cmd.walk_init) begin
      la  <= best;
      acc <= '0;
    end else if (cmd.acc_add) begin
      la  <= idx + 1'b1;
      acc <= acc + ACC_W'(root);
    end
    if (cmd.prev_load || cmd.acc_add) begin
      prev_x <= pt_x;
      prev_y <= pt_y;
    end
  end

  // iterative square root, two radicand bits per step
  logic [ppst_pkg::D2_W-1:0]   sw;
  logic [ppst_pkg::REM_W-1:0]  rem;
  logic [ppst_pkg::REM_W+1:0]  remx, trial;
  logic [ppst_pkg::ITER_W-1:0] iter;

  assign remx  = {rem, sw[ppst_pkg::D2_W-1 -: 2]};
  assign trial = (ppst_pkg::REM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sw   <= d2;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sw <= {sw[ppst_pkg::D2_W-3:0], 2'b00};
      if (remx >= trial) begin
        rem  <= ppst_pkg::REM_W'(remx - trial);
        root <= {root[ppst_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= ppst_pkg::REM_W'(remx);
        root <= {root[ppst_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // step counter shared by square root and divider
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      iter <= ppst_pkg::SQRT_LAST_ITER;
    end else if (cmd.div_start) begin
      iter <= ppst_pkg::DIV_LAST_ITER;
    end else if (cmd.sqrt_step || cmd.div_step) begin
      iter <= iter - 1'b1;
    end
  end

  // sine and cosine pipeline, lane 0 sine, lane 1 cosine
  logic [15:0]        hk  [2];
  logic [1:0]         sq0 [2], sq1 [2], sq2 [2], sq3 [2];
  logic [14:0]        sz0 [2], sz1 [2], sz2 [2], sz3 [2];
  logic [14:0]        zz1 [2], zz2 [2], tt2 [2];
  logic [15:0]        uu3 [2];
  logic signed [15:0] trig [2];
  logic [29:0]        p1 [2], p3 [2];
  logic [26:0]        p2 [2];
  logic [30:0]        p4 [2];
  logic [14:0]        sc [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hk[k] = (k == 0) ? hd : hd + ppst_pkg::QUARTER_TURN;
      p1[k] = sz0[k] * sz0[k];
      p2[k] = zz1[k] * ppst_pkg::SIN_C2;
      p3[k] = zz2[k] * tt2[k];
      p4[k] = sz3[k] * uu3[k];
      sc[k] = (p4[k][30:14] > 17'd32767) ? 15'h7fff : p4[k][28:14];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      sq0[k] <= hk[k][15:14];
      sz0[k] <= hk[k][14] ? 15'(ppst_pkg::QUARTER_TURN - {2'b00, hk[k][13:0]})
                          : {1'b0, hk[k][13:0]};
      sq1[k] <= sq0[k];
      sz1[k] <= sz0[k];
      zz1[k] <= p1[k][28:14];
      sq2[k] <= sq1[k];
      sz2[k] <= sz1[k];
      zz2[k] <= zz1[k];
      tt2[k] <= ppst_pkg::SIN_C1 - {2'b00, p2[k][26:14]};
      sq3[k] <= sq2[k];
      sz3[k] <= sz2[k];
      uu3[k] <= ppst_pkg::SIN_C3 - {1'b0, p3[k][28:14]};
      trig[k] <= sq3[k][1] ? -$signed({1'b0, sc[k]}) : $signed({1'b0, sc[k]});
    end
  end

  // lateral offset and turn numerator
  logic signed [48:0]               m1, m2;
  logic signed [ppst_pkg::LAT_W-1:0] lat;
  logic [ppst_pkg::LAT_W-1:0]        ul;
  logic [ppst_pkg::DIFF_W-1:0]       v4;
  logic [ppst_pkg::PP_W-1:0]         pp_lo, pp_hi;
  logic [ppst_pkg::NUM_W-1:0]        num;
  logic [ppst_pkg::DSH_W-1:0]        dsh;
  logic [ppst_pkg::QUO_W-1:0]        quo;
  logic                              num_ge;

  assign ul     = lat[ppst_pkg::LAT_W-1] ? ppst_pkg::LAT_W'(-lat) : lat;
  assign v4     = {max_speed, 2'b00};
  assign num_ge = (dsh[ppst_pkg::DSH_W-1:ppst_pkg::NUM_W] == '0)
               && (num >= dsh[ppst_pkg::NUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.lat_mul) begin
      m1 <= 49'(trig[0]) * 49'(dxs);
      m2 <= 49'(trig[1]) * 49'(dys);
    end
    if (cmd.lat_add) begin
      lat <= ppst_pkg::LAT_W'(m2) - ppst_pkg::LAT_W'(m1);
    end
    if (cmd.num_lo) begin
      pp_lo <= v4 * ul[ppst_pkg::HALF_W-1:0];
    end
    if (cmd.num_hi) begin
      pp_hi <= v4 * ul[ppst_pkg::LAT_W-1:ppst_pkg::HALF_W];
    end
  end

  // restoring divider, one quotient bit per step from bit 31 down
  always_ff @(posedge clk) begin
    if (cmd.num_add) begin
      num <= ppst_pkg::NUM_W'(pp_lo) + ppst_pkg::NUM_W'({pp_hi, {ppst_pkg::HALF_W{1'b0}}});
    end else if (cmd.div_step && num_ge) begin
      num <= num - dsh[ppst_pkg::NUM_W-1:0];
    end
    if (cmd.div_start) begin
      dsh <= {d2, {(ppst_pkg::DSH_W-ppst_pkg::D2_W){1'b0}}};
      quo <= '0;
    end else if (cmd.div_step) begin
      dsh <= dsh >> 1;
      quo <= {quo[ppst_pkg::QUO_W-2:0], num_ge};
    end
  end

  // reached test
  logic [61:0] stop2;
  logic        reach_r;

  always_ff @(posedge clk) begin
    stop2 <= stop_m * stop_m;
    if (cmd.reach_load) begin
      reach_r <= ({4'b0000, stop2} >= d2);
    end
  end

  // result register
  logic [ppst_pkg::CFG_W-1:0] qc;
  logic signed [31:0]         turn_v;

  assign qc     = (quo > 32'(max_turn)) ? max_turn : quo[ppst_pkg::CFG_W-1:0];
  assign turn_v = lat[ppst_pkg::LAT_W-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (empty) begin
        speed_cmd    <= '0;
        turn_cmd     <= '0;
        target_index <= '0;
        reached      <= 1'b1;
      end else begin
        speed_cmd    <= (d2 == '0) ? '0 : {1'b0, max_speed};
        turn_cmd     <= (d2 == '0) ? '0 : turn_v;
        target_index <= 8'(la);
        reached      <= reach_r;
      end
    end
  end

  // status
  assign sts.count_zero = (count == '0);
  assign sts.last_idx   = ({1'b0, idx} == cnt_m1);
  assign sts.has_next   = (({1'b0, idx} + 1'b1) < count);
  assign sts.iter_last  = (iter == '0);
  assign sts.acc_ge     = (acc >= ACC_W'(la_dist));
  assign sts.d2_zero    = (d2 == '0);

endmodule

/* design/pure_pursuit_steering.sv */
// pure_pursuit_steering: top level of the pure pursuit path tracker.
// Joins ppst_ctrl and ppst_dp; uses types and constants from ppst_pkg.
//
// A mode 0 item appends a path point (restart_path starts a new path with it; a
// point beyond the store depth is dropped) and gives no result; a mode 1 item
// (pose) gives one result. The closest point search reads the points one at a
// time through the single read port of the path store, each walked segment
// passes through the bit-pair square root unit, and the turn rate comes from a
// 32-step restoring divider. One pose is worked at a time; a finished result
// waits in the output register while the next item is taken. No clearing pass
// after reset: the store is only read below the fill count.
module pure_pursuit_steering #(
  parameter int PATH_DEPTH = ppst_pkg::PATH_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic                        restart_path,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic [15:0]                 heading,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          speed_cmd,
  output logic signed [31:0]          turn_cmd,
  output logic [7:0]                  target_index,
  output logic                        reached,
  input  logic                        cfg_we,
  input  logic [ppst_pkg::IDXR_W-1:0] cfg_index,
  input  logic [ppst_pkg::CFG_W-1:0]  cfg_data
);

  ppst_pkg::ppst_cmd_t cmd;
  ppst_pkg::ppst_sts_t sts;

  ppst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppst_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart_path (restart_path),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading      (heading),
    .speed_cmd    (speed_cmd),
    .turn_cmd     (turn_cmd),
    .target_index (target_index),
    .reached      (reached)
  );

endmodule

/* design/ppst_chk.sv */
// ppst_chk: port-level checks for pure_pursuit_steering, bound to the top.
// Depends only on the top level's ports.
module ppst_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        mode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [31:0]          speed_cmd,
  input logic signed [31:0]          turn_cmd
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(turn_cmd))
    else $error("stalled result changed");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a pose transfer makes the block busy
  a_pose_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode |=> in_stall)
    else $error("pose transfer did not start work");

  // speed command is never negative
  a_speed_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !speed_cmd[31])
    else $error("negative speed command");

  // turning needs a nonzero speed
  a_turn_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && turn_cmd != 0 |-> speed_cmd != 0)
    else $error("turn command without speed");

endmodule

bind pure_pursuit_steering ppst_chk u_ppst_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .speed_cmd (speed_cmd),
  .turn_cmd  (turn_cmd)
);
